FILE: src/msrd_pkg.sv
// Package for the mount status reply decoder: item types, flag indexes, codes and characters.
`timescale 1ns / 1ps

package msrd_pkg;

    // Input item: one reply character plus framing and slew-status data
    typedef struct packed {
        logic [7:0] reply_char;
        logic       is_final;
        logic       reply_empty;
        logic [7:0] slew_byte;
        logic       slew_byte_present;
    } t_in_item;

    // Result item: decoded mount status
    typedef struct packed {
        logic       tracking;
        logic [2:0] park_state;
        logic       at_home;
        logic       goto_active;
        logic [1:0] pier_side;
        logic [2:0] activity;
        logic       error_valid;
        logic [3:0] error_code;
        logic       rate_valid;
        logic [3:0] slew_rate;
        logic       replied;
    } t_out_item;

    localparam int NUM_FLAGS = 12;

    // Accumulated reply state, including the item being taken in
    typedef struct packed {
        logic [NUM_FLAGS-1:0] flags;
        logic [7:0]           newest;
        logic [7:0]           older;
        logic [1:0]           count;
    } t_view;

    // Flag bit positions
    localparam int FB_TRK_OFF  = 0;
    localparam int FB_FAILED   = 1;
    localparam int FB_PARKING  = 2;
    localparam int FB_PARKED   = 3;
    localparam int FB_UNPARKED = 4;
    localparam int FB_HOME     = 5;
    localparam int FB_NO_GOTO  = 6;
    localparam int FB_WEST     = 7;
    localparam int FB_EAST     = 8;
    localparam int FB_MANUAL   = 9;
    localparam int FB_GUIDE    = 10;
    localparam int FB_HOMING   = 11;

    // Characters of interest
    localparam logic [7:0] CH_TRK_OFF  = 8'h6E; // n
    localparam logic [7:0] CH_FAILED   = 8'h46; // F
    localparam logic [7:0] CH_PARKING  = 8'h49; // I
    localparam logic [7:0] CH_PARKED   = 8'h50; // P
    localparam logic [7:0] CH_UNPARKED = 8'h70; // p
    localparam logic [7:0] CH_HOME     = 8'h48; // H
    localparam logic [7:0] CH_NO_GOTO  = 8'h4E; // N
    localparam logic [7:0] CH_WEST     = 8'h57; // W
    localparam logic [7:0] CH_EAST     = 8'h54; // T
    localparam logic [7:0] CH_MANUAL   = 8'h67; // g
    localparam logic [7:0] CH_GUIDE    = 8'h47; // G
    localparam logic [7:0] CH_HOMING   = 8'h68; // h
    localparam logic [7:0] CH_ZERO     = 8'h30; // 0
    localparam logic [7:0] CH_ONE      = 8'h31; // 1
    localparam logic [7:0] CH_NINE     = 8'h39; // 9

    localparam logic [7:0] SLEW_MOVING = 8'h7F;

    // Park state codes
    localparam logic [2:0] PARK_UNKNOWN  = 3'd0;
    localparam logic [2:0] PARK_UNPARKED = 3'd1;
    localparam logic [2:0] PARK_PARKED   = 3'd2;
    localparam logic [2:0] PARK_PARKING  = 3'd3;
    localparam logic [2:0] PARK_FAILED   = 3'd4;

    // Pier side codes
    localparam logic [1:0] PIER_NONE = 2'd0;
    localparam logic [1:0] PIER_EAST = 2'd1;
    localparam logic [1:0] PIER_WEST = 2'd2;

    // Activity codes
    localparam logic [2:0] ACT_IDLE    = 3'd0;
    localparam logic [2:0] ACT_MANUAL  = 3'd1;
    localparam logic [2:0] ACT_PARKING = 3'd2;
    localparam logic [2:0] ACT_HOMING  = 3'd3;
    localparam logic [2:0] ACT_GOTO    = 3'd4;
    localparam logic [2:0] ACT_GUIDE   = 3'd5;

    // One-hot flag mask for a character, zero for any other character
    function automatic logic [NUM_FLAGS-1:0] flag_mask(input logic [7:0] ch);
        logic [NUM_FLAGS-1:0] m;
        m = '0;
        unique case (ch)
            CH_TRK_OFF:  m[FB_TRK_OFF]  = 1'b1;
            CH_FAILED:   m[FB_FAILED]   = 1'b1;
            CH_PARKING:  m[FB_PARKING]  = 1'b1;
            CH_PARKED:   m[FB_PARKED]   = 1'b1;
            CH_UNPARKED: m[FB_UNPARKED] = 1'b1;
            CH_HOME:     m[FB_HOME]     = 1'b1;
            CH_NO_GOTO:  m[FB_NO_GOTO]  = 1'b1;
            CH_WEST:     m[FB_WEST]     = 1'b1;
            CH_EAST:     m[FB_EAST]     = 1'b1;
            CH_MANUAL:   m[FB_MANUAL]   = 1'b1;
            CH_GUIDE:    m[FB_GUIDE]    = 1'b1;
            CH_HOMING:   m[FB_HOMING]   = 1'b1;
            default:     m = '0;
        endcase
        return m;
    endfunction

endpackage

FILE: src/msrd_flags.sv
// Reply state: seen-flag bits, last two characters and saturating character count.
`timescale 1ns / 1ps

module msrd_flags (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_adv,
    input  msrd_pkg::t_in_item  i_item,
    output msrd_pkg::t_view     o_view
);

    logic [msrd_pkg::NUM_FLAGS-1:0] r_flags;
    logic [7:0]                     r_newest;
    logic [7:0]                     r_older;
    logic [1:0]                     r_count;

    // State merged with the current character
    always_comb begin
        o_view.flags  = r_flags | msrd_pkg::flag_mask(i_item.reply_char);
        o_view.newest = i_item.reply_char;
        o_view.older  = r_newest;
        o_view.count  = (r_count == 2'd2) ? 2'd2 : r_count + 2'd1;
    end

    // Update on every advanced non-empty item; a final item leaves the state cleared
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_flags  <= '0;
            r_newest <= '0;
            r_older  <= '0;
            r_count  <= '0;
        end else if (i_adv) begin
            if (i_item.is_final) begin
                r_flags  <= '0;
                r_newest <= '0;
                r_older  <= '0;
                r_count  <= '0;
            end else if (!i_item.reply_empty) begin
                r_flags  <= o_view.flags;
                r_newest <= o_view.newest;
                r_older  <= o_view.older;
                r_count  <= o_view.count;
            end
        end
    end

    // A final item starts the next reply from a clean state
    a_final_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_adv && i_item.is_final) |=> (r_flags == '0 && r_count == 2'd0))
        else $error("state not cleared after final item");

    // A non-final character is always counted
    a_char_counted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_adv && !i_item.is_final && !i_item.reply_empty) |=> (r_count != 2'd0))
        else $error("character not counted");

endmodule

FILE: src/msrd_decode.sv
// Status decode: turns the accumulated reply state into one result item.
`timescale 1ns / 1ps

module msrd_decode (
    input  msrd_pkg::t_in_item  i_item,
    input  msrd_pkg::t_view     i_view,
    output msrd_pkg::t_out_item o_item
);

    logic [msrd_pkg::NUM_FLAGS-1:0] f;
    logic                           gta;
    logic                           ev;
    logic                           rv;
    logic                           slewing;
    logic [7:0]                     err_diff;
    logic [7:0]                     rate_diff;
    msrd_pkg::t_out_item            dec;

    assign f         = i_view.flags;
    assign gta       = !f[msrd_pkg::FB_NO_GOTO];
    assign ev        = (i_view.newest >= msrd_pkg::CH_ZERO) &&
                       (i_view.newest <= msrd_pkg::CH_NINE);
    assign rv        = (i_view.count == 2'd2) &&
                       (i_view.older >= msrd_pkg::CH_ONE) &&
                       (i_view.older <= msrd_pkg::CH_NINE);
    assign slewing   = i_item.slew_byte_present &&
                       (i_item.slew_byte == msrd_pkg::SLEW_MOVING) && gta;
    assign err_diff  = i_view.newest - msrd_pkg::CH_ZERO;
    assign rate_diff = i_view.older - msrd_pkg::CH_ZERO;

    always_comb begin
        dec.tracking    = !f[msrd_pkg::FB_TRK_OFF];
        dec.at_home     = f[msrd_pkg::FB_HOME];
        dec.goto_active = gta;

        // Park state by precedence
        if (f[msrd_pkg::FB_FAILED])        dec.park_state = msrd_pkg::PARK_FAILED;
        else if (f[msrd_pkg::FB_PARKING])  dec.park_state = msrd_pkg::PARK_PARKING;
        else if (f[msrd_pkg::FB_PARKED])   dec.park_state = msrd_pkg::PARK_PARKED;
        else if (f[msrd_pkg::FB_UNPARKED]) dec.park_state = msrd_pkg::PARK_UNPARKED;
        else                               dec.park_state = msrd_pkg::PARK_UNKNOWN;

        // Pier side: west wins
        if (f[msrd_pkg::FB_WEST])      dec.pier_side = msrd_pkg::PIER_WEST;
        else if (f[msrd_pkg::FB_EAST]) dec.pier_side = msrd_pkg::PIER_EAST;
        else                           dec.pier_side = msrd_pkg::PIER_NONE;

        // Activity by fixed precedence
        if (f[msrd_pkg::FB_MANUAL])       dec.activity = msrd_pkg::ACT_MANUAL;
        else if (f[msrd_pkg::FB_PARKING]) dec.activity = msrd_pkg::ACT_PARKING;
        else if (f[msrd_pkg::FB_HOMING])  dec.activity = msrd_pkg::ACT_HOMING;
        else if (slewing)                 dec.activity = msrd_pkg::ACT_GOTO;
        else if (f[msrd_pkg::FB_GUIDE])   dec.activity = msrd_pkg::ACT_GUIDE;
        else                              dec.activity = msrd_pkg::ACT_IDLE;

        // Trailing digits
        dec.error_valid = ev;
        dec.error_code  = ev ? err_diff[3:0] : 4'd0;
        dec.rate_valid  = rv;
        dec.slew_rate   = rv ? rate_diff[3:0] : 4'd0;
        dec.replied     = 1'b1;

        // Empty reply gives all-zero defaults
        o_item = i_item.reply_empty ? '0 : dec;
    end

endmodule

FILE: src/mount_status_reply_decoder.sv
// Top level of the mount status reply decoder: input register, state, decode, result register.
`timescale 1ns / 1ps

// Feed the status reply one character per item, marking the last with is_final
// (an empty reply is one item with reply_empty and is_final set). The final item
// also carries the first slew-status byte. One item is taken every clock cycle
// while no result waits to be taken. An item is held in the input register; when it
// advances, its result, if any, is loaded into the output register until taken.
// Both stages stall only while a result waits to be taken.
// A non-final item with reply_empty set is dropped without effect.
module mount_status_reply_decoder (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  msrd_pkg::t_in_item  i_in_item,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output msrd_pkg::t_out_item o_out_item
);

    logic                r_in_valid;
    msrd_pkg::t_in_item  r_in_item;
    logic                r_out_valid;
    msrd_pkg::t_out_item r_out_item;
    logic                adv;
    msrd_pkg::t_view     view;
    msrd_pkg::t_out_item n_out_item;

    // Stage advances whenever the result register is free or being emptied
    assign adv        = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || adv;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in_item <= i_in_item;
        end
    end

    msrd_flags u_flags (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (adv),
        .i_item  (r_in_item),
        .o_view  (view)
    );

    msrd_decode u_decode (
        .i_item (r_in_item),
        .i_view (view),
        .o_item (n_out_item)
    );

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv && r_in_item.is_final) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv && r_in_item.is_final) begin
            r_out_item <= n_out_item;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    // A final item always yields a result
    a_final_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (adv && r_in_item.is_final) |=> r_out_valid)
        else $error("final item produced no result");

    // Empty-reply defaults carry no status
    a_empty_defaults: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out_item.replied) |->
            (!r_out_item.tracking && !r_out_item.goto_active &&
             r_out_item.activity == msrd_pkg::ACT_IDLE))
        else $error("empty reply result not at defaults");

endmodule

FILE: sim/tb_mount_status_reply_decoder.sv
// Testbench for the mount status reply decoder: directed and random replies, scoreboard check.
`timescale 1ns / 1ps

module tb_mount_status_reply_decoder;
    import msrd_pkg::*;

    // Predicts the decoded status of each reply and checks results in order
    class status_scoreboard;
        logic [NUM_FLAGS-1:0] seen_flags;
        logic [7:0]           last_char;
        logic [7:0]           prev_char;
        int unsigned          char_total;
        t_out_item            pending_status[$];
        int unsigned          mismatches;

        function new();
            mismatches = 0;
            clear_reply();
        endfunction

        function void clear_reply();
            seen_flags = '0;
            last_char  = '0;
            prev_char  = '0;
            char_total = 0;
        endfunction

        function int unsigned pending();
            return pending_status.size();
        endfunction

        // Called for every accepted input item
        function void note_char(t_in_item it);
            t_out_item st;
            logic      goto_ok;
            logic      err_ok;
            logic      rate_ok;
            st = '0;
            // empty marker: ignored unless it closes the reply
            if (it.reply_empty) begin
                if (it.is_final) begin
                    pending_status.push_back(st);
                    clear_reply();
                end
                return;
            end
            case (it.reply_char)
                CH_TRK_OFF:  seen_flags[FB_TRK_OFF]  = 1'b1;
                CH_FAILED:   seen_flags[FB_FAILED]   = 1'b1;
                CH_PARKING:  seen_flags[FB_PARKING]  = 1'b1;
                CH_PARKED:   seen_flags[FB_PARKED]   = 1'b1;
                CH_UNPARKED: seen_flags[FB_UNPARKED] = 1'b1;
                CH_HOME:     seen_flags[FB_HOME]     = 1'b1;
                CH_NO_GOTO:  seen_flags[FB_NO_GOTO]  = 1'b1;
                CH_WEST:     seen_flags[FB_WEST]     = 1'b1;
                CH_EAST:     seen_flags[FB_EAST]     = 1'b1;
                CH_MANUAL:   seen_flags[FB_MANUAL]   = 1'b1;
                CH_GUIDE:    seen_flags[FB_GUIDE]    = 1'b1;
                CH_HOMING:   seen_flags[FB_HOMING]   = 1'b1;
                default: ;
            endcase
            prev_char = last_char;
            last_char = it.reply_char;
            if (char_total < 2)
                char_total++;
            if (!it.is_final)
                return;

            goto_ok = !seen_flags[FB_NO_GOTO];
            err_ok  = (last_char >= CH_ZERO) && (last_char <= CH_NINE);
            rate_ok = (char_total >= 2) && (prev_char >= CH_ONE) && (prev_char <= CH_NINE);

            st.tracking    = !seen_flags[FB_TRK_OFF];
            st.at_home     = seen_flags[FB_HOME];
            st.goto_active = goto_ok;
            st.replied     = 1'b1;

            if (seen_flags[FB_FAILED])        st.park_state = PARK_FAILED;
            else if (seen_flags[FB_PARKING])  st.park_state = PARK_PARKING;
            else if (seen_flags[FB_PARKED])   st.park_state = PARK_PARKED;
            else if (seen_flags[FB_UNPARKED]) st.park_state = PARK_UNPARKED;
            else                              st.park_state = PARK_UNKNOWN;

            if (seen_flags[FB_WEST])      st.pier_side = PIER_WEST;
            else if (seen_flags[FB_EAST]) st.pier_side = PIER_EAST;
            else                          st.pier_side = PIER_NONE;

            // fixed precedence of activities
            if (seen_flags[FB_MANUAL])       st.activity = ACT_MANUAL;
            else if (seen_flags[FB_PARKING]) st.activity = ACT_PARKING;
            else if (seen_flags[FB_HOMING])  st.activity = ACT_HOMING;
            else if (it.slew_byte_present && it.slew_byte == SLEW_MOVING && goto_ok)
                st.activity = ACT_GOTO;
            else if (seen_flags[FB_GUIDE])   st.activity = ACT_GUIDE;
            else                             st.activity = ACT_IDLE;

            st.error_valid = err_ok;
            st.error_code  = err_ok ? 4'(last_char - CH_ZERO) : 4'd0;
            st.rate_valid  = rate_ok;
            st.slew_rate   = rate_ok ? 4'(prev_char - CH_ZERO) : 4'd0;

            pending_status.push_back(st);
            clear_reply();
        endfunction

        function void cmp_field(string field, int unsigned want, int unsigned got);
            if (want != got) begin
                $error("%s: expected %0d, got %0d", field, want, got);
                mismatches++;
            end
        endfunction

        // Called for every accepted result item
        function void check_status(t_out_item got);
            t_out_item want;
            if (pending_status.size() == 0) begin
                $error("status result with none outstanding: %h", got);
                mismatches++;
                return;
            end
            want = pending_status.pop_front();
            cmp_field("tracking",    want.tracking,    got.tracking);
            cmp_field("park_state",  want.park_state,  got.park_state);
            cmp_field("at_home",     want.at_home,     got.at_home);
            cmp_field("goto_active", want.goto_active, got.goto_active);
            cmp_field("pier_side",   want.pier_side,   got.pier_side);
            cmp_field("activity",    want.activity,    got.activity);
            cmp_field("error_valid", want.error_valid, got.error_valid);
            cmp_field("error_code",  want.error_code,  got.error_code);
            cmp_field("rate_valid",  want.rate_valid,  got.rate_valid);
            cmp_field("slew_rate",   want.slew_rate,   got.slew_rate);
            cmp_field("replied",     want.replied,     got.replied);
        endfunction
    endclass

    logic      i_clk       = 1'b0;
    logic      i_rst_n     = 1'b0;
    logic      i_in_valid  = 1'b0;
    logic      o_in_ready;
    t_in_item  i_in_item   = '0;
    logic      o_out_valid;
    logic      i_out_ready = 1'b0;
    t_out_item o_out_item;

    status_scoreboard sb = new();
    int unsigned      items_sent = 0;
    bit               quiet = 1'b0;

    mount_status_reply_decoder dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item)
    );

    always #6 i_clk = ~i_clk;

    // Monitors: sample both handshakes at the rising edge
    always @(posedge i_clk) begin
        if (i_rst_n && i_in_valid && o_in_ready)
            sb.note_char(i_in_item);
        if (i_rst_n && o_out_valid && i_out_ready)
            sb.check_status(o_out_item);
    end

    // Result side: random stall bursts, none once quiet
    initial begin
        int stall_left;
        stall_left = 0;
        forever begin
            @(negedge i_clk);
            if (stall_left > 0) begin
                stall_left--;
                i_out_ready <= 1'b0;
            end else if (!quiet && $urandom_range(0, 6) == 0) begin
                stall_left = $urandom_range(1, 15) - 1;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    function automatic t_in_item make_item(logic [7:0] ch, logic fin, logic empty,
                                           logic [7:0] sbyte, logic sb_on);
        t_in_item it;
        it.reply_char        = ch;
        it.is_final          = fin;
        it.reply_empty       = empty;
        it.slew_byte         = sbyte;
        it.slew_byte_present = sb_on;
        return it;
    endfunction

    // Drive one item; entered and left at a falling edge
    task automatic send_item(t_in_item it);
        int gap;
        if (!quiet && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 15);
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_item  <= it;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        @(negedge i_clk);
        if (!(it.reply_empty && !it.is_final))
            items_sent++;
    endtask

    task automatic send_char(logic [7:0] ch, logic fin, logic [7:0] sbyte, logic sb_on);
        send_item(make_item(ch, fin, 1'b0, sbyte, sb_on));
    endtask

    task automatic send_empty(logic fin);
        send_item(make_item(8'($urandom_range(0, 255)), fin, 1'b1,
                            8'($urandom_range(0, 255)), 1'($urandom_range(0, 1))));
    endtask

    // Mostly flag letters and digits, some arbitrary bytes
    function automatic logic [7:0] pick_char();
        logic [7:0] ch;
        case ($urandom_range(0, 3))
            0, 1: begin
                case ($urandom_range(0, 11))
                    0:  ch = CH_TRK_OFF;
                    1:  ch = CH_FAILED;
                    2:  ch = CH_PARKING;
                    3:  ch = CH_PARKED;
                    4:  ch = CH_UNPARKED;
                    5:  ch = CH_HOME;
                    6:  ch = CH_NO_GOTO;
                    7:  ch = CH_WEST;
                    8:  ch = CH_EAST;
                    9:  ch = CH_MANUAL;
                    10: ch = CH_GUIDE;
                    default: ch = CH_HOMING;
                endcase
            end
            2:       ch = CH_ZERO + 8'($urandom_range(0, 9));
            default: ch = 8'($urandom_range(0, 255));
        endcase
        return ch;
    endfunction

    // One random reply: well-formed most of the time, sometimes cut short
    task automatic random_reply();
        int         len;
        int         kind;
        logic [7:0] sbyte;
        logic       sb_on;
        len  = $urandom_range(1, 8);
        kind = $urandom_range(0, 9);
        if (kind == 0) begin
            send_empty(1'b1);
            return;
        end
        for (int k = 0; k < len; k++) begin
            if ($urandom_range(0, 11) == 0)
                send_empty(1'b0);
            sbyte = ($urandom_range(0, 2) == 0) ? 8'($urandom_range(0, 255)) : SLEW_MOVING;
            sb_on = ($urandom_range(0, 3) != 0);
            // broken reply: the closing item is an empty marker instead
            if (k == len - 1 && kind == 1)
                send_empty(1'b1);
            else
                send_char(pick_char(), k == len - 1, sbyte, sb_on);
        end
    endtask

    // Main sequence
    initial begin
        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // empty reply straight after reset
        send_empty(1'b1);
        // single digit reply, slew moving
        send_char(CH_NINE, 1'b1, SLEW_MOVING, 1'b1);
        // tracking off, failed, home, west beats east, manual, rate 1 error 0
        send_char(CH_TRK_OFF, 1'b0, 8'h00, 1'b0);
        send_char(CH_FAILED,  1'b0, 8'h00, 1'b0);
        send_char(CH_HOME,    1'b0, 8'h00, 1'b0);
        send_char(CH_WEST,    1'b0, 8'h00, 1'b0);
        send_char(CH_EAST,    1'b0, 8'h00, 1'b0);
        send_char(CH_MANUAL,  1'b0, 8'h00, 1'b0);
        send_char(CH_ONE,     1'b0, 8'h00, 1'b0);
        send_char(CH_ZERO,    1'b1, 8'hFF, 1'b1);
        // parking wins, no goto, older digit zero gives no rate
        send_char(CH_PARKING,  1'b0, 8'h00, 1'b0);
        send_char(CH_PARKED,   1'b0, 8'h00, 1'b0);
        send_char(CH_UNPARKED, 1'b0, 8'h00, 1'b0);
        send_char(CH_NO_GOTO,  1'b0, 8'h00, 1'b0);
        send_char(CH_HOMING,   1'b0, 8'h00, 1'b0);
        send_char(CH_GUIDE,    1'b0, 8'h00, 1'b0);
        send_char(CH_ZERO,     1'b0, 8'h00, 1'b0);
        send_char(CH_NINE,     1'b1, SLEW_MOVING, 1'b1);
        // homing, extreme bytes, ignored empty marker, slew byte absent
        send_char(CH_UNPARKED, 1'b0, 8'h00, 1'b0);
        send_char(CH_HOMING,   1'b0, 8'h00, 1'b0);
        send_char(8'hFF,       1'b0, 8'hFF, 1'b1);
        send_empty(1'b0);
        send_char(8'h00,       1'b1, SLEW_MOVING, 1'b0);
        // goto slew beats pulse guide
        send_char(CH_PARKED, 1'b0, 8'h00, 1'b0);
        send_char(CH_EAST,   1'b0, 8'h00, 1'b0);
        send_char(CH_GUIDE,  1'b1, SLEW_MOVING, 1'b1);
        // partial reply closed by an empty marker gives defaults
        send_char(CH_TRK_OFF, 1'b0, 8'h00, 1'b0);
        send_empty(1'b1);

        while (items_sent < 1600) begin
            if (items_sent >= 1450)
                quiet = 1'b1;
            random_reply();
        end
        i_in_valid <= 1'b0;

        while (sb.pending() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (sb.mismatches == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    // Watchdog
    initial begin
        #10ms;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule

FILE: filelist.f
src/msrd_pkg.sv
src/msrd_flags.sv
src/msrd_decode.sv
src/mount_status_reply_decoder.sv
sim/tb_mount_status_reply_decoder.sv
